// ===== sv/mset_pkg.sv =====
package mset_pkg;

    localparam int CFG_W    = 5;
    localparam int TARGET_W = 4;
    localparam int CMD_W    = 2;

    localparam logic [CFG_W-1:0] COUNT_RESET = 5'd16;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_START   = 2'd0;
    localparam cmd_t CMD_STOP    = 2'd1;
    localparam cmd_t CMD_ADVANCE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_UPD,
        ST_FLUSH
    } state_t;

endpackage

// ===== sv/mset_if.sv =====
interface mset_req_if
    import mset_pkg::*;
#(
    parameter int EVENT_BITS = 8,
    parameter int TIME_BITS  = 24
) ();

    logic                  valid;
    logic                  ready;
    cmd_t                  cmd;
    logic [EVENT_BITS-1:0] event_id;
    logic [TARGET_W-1:0]   target_id;
    logic [TIME_BITS-1:0]  amount_ms;
    logic                  periodic_mode;

    modport source (
        output valid, cmd, event_id, target_id, amount_ms, periodic_mode,
        input  ready
    );

    modport sink (
        input  valid, cmd, event_id, target_id, amount_ms, periodic_mode,
        output ready
    );

endinterface

interface mset_exp_if
    import mset_pkg::*;
#(
    parameter int EVENT_BITS = 8
) ();

    logic                  valid;
    logic                  ready;
    logic [EVENT_BITS-1:0] fired_event;
    logic [TARGET_W-1:0]   fired_target;
    logic                  last_of_run;

    modport source (
        output valid, fired_event, fired_target, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, fired_event, fired_target, last_of_run,
        output ready
    );

endinterface

// ===== sv/multi_slot_event_timer_table.sv =====
// Start: scans slots in ST_READ, up to the first free slot.
// Stop: each slot scanned goes through ST_READ (slot RAM read), then ST_ADD (event compare).
// Advance: each slot goes through ST_READ and ST_ADD, an eligible running slot also ST_UPD,
//   then one final ST_FLUSH; output stalls hold ST_UPD and ST_FLUSH. Ready again after.
// Async reset clears the sequencer, the used bits and sets the slot count to 16;
//   the slot RAM is not cleared.
module multi_slot_event_timer_table
    import mset_pkg::*;
#(
    parameter int NUM_SLOTS  = 16,
    parameter int EVENT_BITS = 8,
    parameter int TIME_BITS  = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data,
    mset_req_if.sink         request,
    mset_exp_if.source       expiry
);

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CLOG_N = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W  = (CLOG_N > CFG_W) ? CLOG_N : CFG_W;
    localparam int ELAP_W = TIME_BITS + 1;
    localparam int SUM_W  = TIME_BITS + 2;

    typedef struct packed {
        logic [EVENT_BITS-1:0] evt;
        logic [TARGET_W-1:0]   target;
        logic [TIME_BITS-1:0]  period;
        logic                  rpt;
        logic [ELAP_W-1:0]     elapsed;
    } slot_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CFG_W-1:0]      count_reg;
    logic [NUM_SLOTS-1:0]  used_reg, used_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg, out_valid_next;

    cmd_t                  cmd_reg;
    logic [EVENT_BITS-1:0] evt_reg;
    logic [TARGET_W-1:0]   tgt_reg;
    logic [TIME_BITS-1:0]  amt_reg;
    logic                  per_reg;
    logic [ELAP_W-1:0]     sum_reg, sum_next;
    logic [EVENT_BITS-1:0] pend_evt_reg, pend_evt_next;
    logic [TARGET_W-1:0]   pend_tgt_reg, pend_tgt_next;
    logic [EVENT_BITS-1:0] out_evt_reg, out_evt_next;
    logic [TARGET_W-1:0]   out_tgt_reg, out_tgt_next;
    logic                  out_last_reg, out_last_next;

    slot_t                 slot_mem [NUM_SLOTS];
    slot_t                 rd_data_reg;
    slot_t                 mem_wdata;
    logic                  mem_we;

    logic                  accept;
    logic [CNT_W-1:0]      cnt_ext;
    logic [CNT_W-1:0]      scan_lim;
    logic                  idx_last;
    logic [SUM_W-1:0]      sum_full;
    logic [ELAP_W-1:0]     sum_sat;
    logic                  elig;
    logic [SUM_W-1:0]      diff;
    logic                  fire;
    logic [ELAP_W-1:0]     new_elapsed;
    logic                  out_free;

    assign request.ready       = (state_reg == ST_IDLE);
    assign accept              = request.valid && request.ready;
    assign expiry.valid        = out_valid_reg;
    assign expiry.fired_event  = out_evt_reg;
    assign expiry.fired_target = out_tgt_reg;
    assign expiry.last_of_run  = out_last_reg;

    assign cnt_ext  = CNT_W'(count_reg);
    assign scan_lim = (cnt_ext > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : cnt_ext;
    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) >= scan_lim;

    // adder / subtractor datapath for advance
    assign sum_full    = {1'b0, rd_data_reg.elapsed} + SUM_W'(amt_reg);
    assign sum_sat     = sum_full[SUM_W-1] ? {ELAP_W{1'b1}} : sum_full[ELAP_W-1:0];
    assign elig        = used_reg[idx_reg]
                         && (rd_data_reg.elapsed < ELAP_W'(rd_data_reg.period));
    assign diff        = {1'b0, sum_reg} - SUM_W'(rd_data_reg.period);
    assign fire        = !diff[SUM_W-1];
    assign new_elapsed = (fire && rd_data_reg.rpt) ? diff[ELAP_W-1:0] : sum_reg;
    assign out_free    = !out_valid_reg || expiry.ready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !expiry.ready;
        sum_next        = sum_reg;
        pend_evt_next   = pend_evt_reg;
        pend_tgt_next   = pend_tgt_reg;
        out_evt_next    = out_evt_reg;
        out_tgt_next    = out_tgt_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_wdata       = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (request.valid && (scan_lim != '0)
                    && ((request.cmd == CMD_START) || (request.cmd == CMD_STOP)
                        || (request.cmd == CMD_ADVANCE)))
                begin
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                if (cmd_reg == CMD_START)
                begin
                    if (!used_reg[idx_reg])
                    begin
                        mem_we            = 1'b1;
                        mem_wdata.evt     = evt_reg;
                        mem_wdata.target  = tgt_reg;
                        mem_wdata.period  = amt_reg;
                        mem_wdata.rpt     = per_reg;
                        mem_wdata.elapsed = '0;
                        used_next[idx_reg] = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    else if (idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                if (cmd_reg == CMD_STOP)
                begin
                    if (used_reg[idx_reg] && (rd_data_reg.evt == evt_reg))
                    begin
                        used_next[idx_reg] = 1'b0;
                        state_next         = ST_IDLE;
                    end
                    else if (idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
                else if (elig)
                begin
                    sum_next   = sum_sat;
                    state_next = ST_UPD;
                end
                else if (idx_last)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end

            ST_UPD:
            begin
                if (!(fire && pend_valid_reg && !out_free))
                begin
                    mem_we            = 1'b1;
                    mem_wdata.elapsed = new_elapsed;
                    if (fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_evt_next   = pend_evt_reg;
                            out_tgt_next   = pend_tgt_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_evt_next   = rd_data_reg.evt;
                        pend_tgt_next   = rd_data_reg.target;
                    end
                    if (idx_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_evt_next    = pend_evt_reg;
                    out_tgt_next    = pend_tgt_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            count_reg      <= COUNT_RESET;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
            begin
                count_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        pend_evt_reg <= pend_evt_next;
        pend_tgt_reg <= pend_tgt_next;
        out_evt_reg  <= out_evt_next;
        out_tgt_reg  <= out_tgt_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            cmd_reg <= request.cmd;
            evt_reg <= request.event_id;
            tgt_reg <= request.target_id;
            amt_reg <= request.amount_ms;
            per_reg <= request.periodic_mode;
        end
    end

    // slot RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

endmodule

// ===== sv/mset_checker.sv =====
module mset_checker
    import mset_pkg::*;
#(
    parameter int EVENT_BITS = 8
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_ready,
    input logic                  exp_valid,
    input logic                  exp_ready,
    input logic [EVENT_BITS-1:0] exp_event,
    input logic [TARGET_W-1:0]   exp_target,
    input logic                  exp_last
);

    a_exp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid && !exp_ready |=> exp_valid)
        else $error("expiry item dropped while stalled");

    a_exp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid && !exp_ready |=> $stable(exp_event) && $stable(exp_target)
                                    && $stable(exp_last))
        else $error("expiry payload changed while stalled");

    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(exp_valid) |-> $past(!req_ready))
        else $error("expiry item appeared while idle");

    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid && !exp_last |-> !req_ready)
        else $error("ready before last item of advance");

endmodule

bind multi_slot_event_timer_table mset_checker #(
    .EVENT_BITS (EVENT_BITS)
) u_mset_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (request.ready),
    .exp_valid  (expiry.valid),
    .exp_ready  (expiry.ready),
    .exp_event  (expiry.fired_event),
    .exp_target (expiry.fired_target),
    .exp_last   (expiry.last_of_run)
);
